@@ hdl/chwd_pkg.sv @@
// Shared types, constants and the arctangent table for the compass heading block.
// No dependencies; used by every module in this folder.
`timescale 1ns / 1ps

package chwd_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_LEN          = 24;

    localparam int IN_W    = 16;  // sample width
    localparam int XY_W    = 20;  // covers negation of -32768 plus CORDIC gain
    localparam int Z_W     = 32;  // Q16 centidegrees, worst case about +/-280 deg
    localparam int OUT_W   = 16;
    localparam int SUM_W   = 18;  // angle plus declination before the wrap

    localparam int DECL_LIMIT = 18000;
    localparam int FULL_TURN  = 36000;
    localparam int ROUND_HALF = 32768;            // 0.5 in Q16
    localparam int HALF_TURN_Q16 = 1179648000;    // 18000 * 65536

    // Working vector of one CORDIC stage
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   zero;   // both axes were zero: angle forced to 0
    } chwd_vec_t;

    // round(atan(2^-i) in degrees * 100 * 65536)
    function automatic logic signed [Z_W-1:0] atan_q16(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:       v = 32'sd294912000;
            1:       v = 32'sd174096719;
            2:       v = 32'sd91987925;
            3:       v = 32'sd46694507;
            4:       v = 32'sd23437865;
            5:       v = 32'sd11730358;
            6:       v = 32'sd5866610;
            7:       v = 32'sd2933484;
            8:       v = 32'sd1466764;
            9:       v = 32'sd733385;
            10:      v = 32'sd366693;
            11:      v = 32'sd183346;
            12:      v = 32'sd91673;
            13:      v = 32'sd45837;
            14:      v = 32'sd22918;
            15:      v = 32'sd11459;
            16:      v = 32'sd5730;
            17:      v = 32'sd2865;
            18:      v = 32'sd1432;
            19:      v = 32'sd716;
            20:      v = 32'sd358;
            21:      v = 32'sd179;
            22:      v = 32'sd90;
            23:      v = 32'sd45;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/chwd_prep.sv @@
// Input stage: zero detect and left half plane fold ahead of the CORDIC.
// Depends on chwd_pkg.
`timescale 1ns / 1ps

module chwd_prep (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [chwd_pkg::IN_W-1:0] field_x,
    input  logic signed [chwd_pkg::IN_W-1:0] field_y,
    output logic                            out_valid,
    input  logic                            out_ready,
    output chwd_pkg::chwd_vec_t             out_vec
);

    logic                valid_reg, valid_next;
    chwd_pkg::chwd_vec_t vec_reg, vec_next;
    logic signed [chwd_pkg::XY_W-1:0] x_ext, y_ext;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

    always_comb begin
        x_ext = chwd_pkg::XY_W'(field_x);
        y_ext = chwd_pkg::XY_W'(field_y);
        vec_next.zero = (field_x == '0) && (field_y == '0);
        if (field_x[chwd_pkg::IN_W-1]) begin
            // fold into right half plane, start at +/-180 deg
            vec_next.x = -x_ext;
            vec_next.y = -y_ext;
            vec_next.z = field_y[chwd_pkg::IN_W-1] ?
                         -chwd_pkg::Z_W'(chwd_pkg::HALF_TURN_Q16) :
                          chwd_pkg::Z_W'(chwd_pkg::HALF_TURN_Q16);
        end else begin
            vec_next.x = x_ext;
            vec_next.y = y_ext;
            vec_next.z = '0;
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            vec_reg <= vec_next;
        end
    end

endmodule

@@ hdl/chwd_cordic_stage.sv @@
// One registered CORDIC vectoring stage with a fixed shift.
// Depends on chwd_pkg.
`timescale 1ns / 1ps

module chwd_cordic_stage #(
    parameter int STAGE_IDX = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  chwd_pkg::chwd_vec_t in_vec,
    output logic                out_valid,
    input  logic                out_ready,
    output chwd_pkg::chwd_vec_t out_vec
);

    localparam logic signed [chwd_pkg::Z_W-1:0] ATAN = chwd_pkg::atan_q16(STAGE_IDX);

    logic                valid_reg, valid_next;
    chwd_pkg::chwd_vec_t vec_reg, vec_next;
    logic signed [chwd_pkg::XY_W-1:0] x_in, y_in, dx, dy;
    logic signed [chwd_pkg::Z_W-1:0]  z_in;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

    always_comb begin
        x_in = in_vec.x;
        y_in = in_vec.y;
        z_in = in_vec.z;
        dx   = y_in >>> STAGE_IDX;
        dy   = x_in >>> STAGE_IDX;
        vec_next.zero = in_vec.zero;
        // rotate toward the x axis; both updates use the old x and y
        if (!y_in[chwd_pkg::XY_W-1]) begin
            vec_next.x = x_in + dx;
            vec_next.y = y_in - dy;
            vec_next.z = z_in + ATAN;
        end else begin
            vec_next.x = x_in - dx;
            vec_next.y = y_in + dy;
            vec_next.z = z_in - ATAN;
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            vec_reg <= vec_next;
        end
    end

endmodule

@@ hdl/chwd_post.sv @@
// Output stage: round Q16 angle to centidegrees, add declination, wrap once.
// Depends on chwd_pkg; its register is the block's output register.
`timescale 1ns / 1ps

module chwd_post (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  chwd_pkg::chwd_vec_t              in_vec,
    input  logic signed [chwd_pkg::IN_W-1:0] decl,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [chwd_pkg::OUT_W-1:0]       heading
);

    logic                              valid_reg, valid_next;
    logic [chwd_pkg::OUT_W-1:0]        heading_reg, heading_next;
    logic signed [chwd_pkg::Z_W-1:0]   rounded;
    logic signed [chwd_pkg::OUT_W-1:0] angle;
    logic signed [chwd_pkg::SUM_W-1:0] sum, wrapped;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign heading   = heading_reg;

    always_comb begin
        rounded = in_vec.z + chwd_pkg::Z_W'(chwd_pkg::ROUND_HALF);
        // floor divide by 65536; result stays within +/-28000
        angle   = in_vec.zero ? '0 : rounded[chwd_pkg::Z_W-1 -: chwd_pkg::OUT_W];
        sum     = chwd_pkg::SUM_W'(angle) + chwd_pkg::SUM_W'(decl);
        if (sum[chwd_pkg::SUM_W-1]) begin
            wrapped = sum + chwd_pkg::SUM_W'(chwd_pkg::FULL_TURN);
        end else if (sum > chwd_pkg::SUM_W'(chwd_pkg::FULL_TURN)) begin
            wrapped = sum - chwd_pkg::SUM_W'(chwd_pkg::FULL_TURN);
        end else begin
            wrapped = sum;
        end
        heading_next = wrapped[chwd_pkg::OUT_W-1:0];
        valid_next   = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            heading_reg <= heading_next;
        end
    end

endmodule

@@ hdl/compass_heading_with_declination.sv @@
// Top level of the compass heading block: prep stage, CORDIC chain, output stage.
// Depends on chwd_pkg, chwd_prep, chwd_cordic_stage and chwd_post.
`timescale 1ns / 1ps

// Compass heading with magnetic declination.
//
// Input channel (s_valid/s_ready): one beat carries a signed magnetometer
// pair s_field_x, s_field_y. Output channel (m_valid/m_ready): one beat per
// input beat carries m_heading_centideg, atan2(y, x) plus declination,
// wrapped into 0..36000 centidegrees (36000 itself is kept).
// Config channel (cfg_valid/cfg_ready): one beat writes the declination in
// centidegrees; values outside +/-18000 are saturated on write. cfg_ready is
// always high. Write it only while no sample is in flight.
//
// Pipeline from input beat to output beat: one fold stage, one register per
// CORDIC iteration, one round/wrap stage; 16 iterations by default, capped at
// the 24-entry table.
// Throughput: one sample pair per cycle while m_ready is high; every stage holds its own valid bit.
// Stall: when m_ready is low, the output stage holds its beat and each stage
// keeps accepting until it is full and the stage after it cannot take a beat,
// so bubbles are squeezed out; nothing is dropped or repeated.
// Reset (aresetn low, synchronous): all valid bits clear, declination = 0.
module compass_heading_with_declination #(
    parameter int CORDIC_STAGES = chwd_pkg::CORDIC_STAGES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // sample input
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [chwd_pkg::IN_W-1:0] s_field_x,
    input  logic signed [chwd_pkg::IN_W-1:0] s_field_y,
    // heading output
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [chwd_pkg::OUT_W-1:0]       m_heading_centideg,
    // declination write
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic signed [chwd_pkg::IN_W-1:0] cfg_declination_centideg
);

    // iterations beyond the table are not run
    localparam int N_RUN = (CORDIC_STAGES < chwd_pkg::ATAN_LEN) ?
                           CORDIC_STAGES : chwd_pkg::ATAN_LEN;

    localparam logic signed [chwd_pkg::IN_W-1:0] DECL_MAX =
        chwd_pkg::IN_W'(chwd_pkg::DECL_LIMIT);

    logic signed [chwd_pkg::IN_W-1:0] decl_reg, decl_next;

    chwd_pkg::chwd_vec_t vec [0:N_RUN];
    logic                vld [0:N_RUN];
    logic                rdy [0:N_RUN];

    // ---- declination register, saturated on write ----
    assign cfg_ready = 1'b1;

    always_comb begin
        if (cfg_declination_centideg > DECL_MAX) begin
            decl_next = DECL_MAX;
        end else if (cfg_declination_centideg < -DECL_MAX) begin
            decl_next = -DECL_MAX;
        end else begin
            decl_next = cfg_declination_centideg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decl_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            decl_reg <= decl_next;
        end
    end

    // ---- fold into right half plane ----
    chwd_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .field_x   (s_field_x),
        .field_y   (s_field_y),
        .out_valid (vld[0]),
        .out_ready (rdy[0]),
        .out_vec   (vec[0])
    );

    // ---- CORDIC vectoring chain, one register per iteration ----
    for (genvar k = 0; k < N_RUN; k++) begin : g_cordic
        chwd_cordic_stage #(
            .STAGE_IDX (k)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (vld[k]),
            .in_ready  (rdy[k]),
            .in_vec    (vec[k]),
            .out_valid (vld[k+1]),
            .out_ready (rdy[k+1]),
            .out_vec   (vec[k+1])
        );
    end

    // ---- round, add declination, wrap; drives the output register ----
    chwd_post u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (vld[N_RUN]),
        .in_ready  (rdy[N_RUN]),
        .in_vec    (vec[N_RUN]),
        .decl      (decl_reg),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .heading   (m_heading_centideg)
    );

endmodule
